// ===== rtl/core/tcr_pkg.sv =====
package tcr_pkg;

    // default widths
    localparam int RADIUS_BITS_DEF = 10;
    localparam int COORD_BITS_DEF  = 13;

    // configuration register file
    localparam int CENTER_W   = 11;
    localparam int THICK_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_THICK    = 2'd2
    } cfg_idx_t;

    localparam logic [CENTER_W-1:0] CENTER_X_RST = 11'd400;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 11'd300;
    localparam logic [THICK_W-1:0]  THICK_RST    = 7'd1;

    // request commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // midpoint decision constants
    localparam int DEC_INIT     = 3;
    localparam int DEC_STEP_NEG = 6;
    localparam int DEC_STEP_POS = 10;

    localparam int POINTS_PER_STEP = 8;
    localparam int PT_IDX_W        = 3;

    // handshake status of the step queue
    typedef struct packed {
        logic full;
        logic avail;
    } tcr_q_stat_t;

endpackage

// ===== rtl/core/thick_circle_rasterizer.sv =====
// channel   dir  handshake            payload
// config    in   cfg_we               cfg_index, cfg_data (center_x, center_y, ring_thickness)
// request   in   in_valid / in_stall  command, base_radius
// point     out  out_valid / out_stall point_x, point_y, last_of_step, circle_done
//
// A step request gives eight points on the point channel, one point per cycle while
// out_stall is low. Requests are taken every cycle until the two-entry step queue
// fills. A start request gives no point; a step while idle is dropped. Reset is
// asynchronous, active low, and leaves the block idle with the config registers
// at their defaults.
module thick_circle_rasterizer #(
    parameter int RADIUS_BITS = tcr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = tcr_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [RADIUS_BITS-1:0]           base_radius,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [COORD_BITS-1:0]     point_x,
    output logic signed [COORD_BITS-1:0]     point_y,
    output logic                             last_of_step,
    output logic                             circle_done
);

    // radius register width: covers base radius plus up to 126 extra rings
    localparam int RAD_W = ((RADIUS_BITS > 7) ? RADIUS_BITS : 7) + 1;
    // queue entry: octant x, octant y, final-point flag
    localparam int ENTRY_W = 2 * RAD_W + 1;

    tcr_pkg::tcr_q_stat_t         q_stat;
    logic                         q_push;
    logic                         q_pop;
    logic [ENTRY_W-1:0]           q_wdata;
    logic [ENTRY_W-1:0]           q_rdata;
    logic [tcr_pkg::CENTER_W-1:0] center_x;
    logic [tcr_pkg::CENTER_W-1:0] center_y;

    // front: config registers, request decode, midpoint state update
    tcr_front #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .base_radius (base_radius),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .center_x    (center_x),
        .center_y    (center_y)
    );

    // short queue of octant positions between front and back
    tcr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    // back: expands each position into its eight mirrored points.
    // Center is read live; the user must change config only while nothing is in flight, the block does not enforce it.
    tcr_back #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .q_data       (q_rdata),
        .center_x     (center_x),
        .center_y     (center_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

// ===== rtl/core/tcr_front.sv =====
module tcr_front #(
    parameter int RADIUS_BITS = tcr_pkg::RADIUS_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [RADIUS_BITS-1:0]             base_radius,
    // to queue
    input  tcr_pkg::tcr_q_stat_t               q_stat,
    output logic                               q_push,
    output logic [2*(((RADIUS_BITS > 7) ? RADIUS_BITS : 7) + 1):0] q_data,
    // center for the back end
    output logic [tcr_pkg::CENTER_W-1:0]       center_x,
    output logic [tcr_pkg::CENTER_W-1:0]       center_y
);

    localparam int RAD_W = ((RADIUS_BITS > 7) ? RADIUS_BITS : 7) + 1;
    localparam int XY_W  = RAD_W + 1;
    localparam int DEC_W = RAD_W + 4;

    logic [tcr_pkg::CENTER_W-1:0] center_x_reg;
    logic [tcr_pkg::CENTER_W-1:0] center_y_reg;
    logic [tcr_pkg::THICK_W-1:0]  thick_reg;

    logic signed [XY_W-1:0]  x_reg, x_next;
    logic signed [XY_W-1:0]  y_reg, y_next;
    logic signed [DEC_W-1:0] d_reg, d_next;
    logic [RAD_W-1:0]        cur_rad_reg, cur_rad_next;
    logic [RAD_W-1:0]        fin_rad_reg, fin_rad_next;
    logic                    active_reg, active_next;

    logic                    accept;
    logic [tcr_pkg::THICK_W-1:0] thick_eff;
    logic [RAD_W-1:0]        start_rad;
    logic [RAD_W-1:0]        new_rad;
    logic signed [DEC_W-1:0] xe, ye;
    logic signed [DEC_W-1:0] d_adv;
    logic signed [XY_W-1:0]  x_adv, y_adv;
    logic                    ring_end;
    logic                    circle_end;
    logic signed [XY_W-1:0]  init_y;
    logic signed [DEC_W-1:0] init_d;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign center_x = center_x_reg;
    assign center_y = center_y_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= tcr_pkg::CENTER_X_RST;
            center_y_reg <= tcr_pkg::CENTER_Y_RST;
            thick_reg    <= tcr_pkg::THICK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcr_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                tcr_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                tcr_pkg::CFG_THICK:    thick_reg    <= cfg_data[tcr_pkg::THICK_W-1:0];
                default:               ;
            endcase
        end
    end

    // one midpoint step
    always_comb
    begin
        xe = DEC_W'(x_reg);
        ye = DEC_W'(y_reg);
        if (d_reg < 0)
        begin
            d_adv = d_reg + (xe <<< 2) + DEC_W'(tcr_pkg::DEC_STEP_NEG);
            y_adv = y_reg;
        end
        else
        begin
            d_adv = d_reg + ((xe - ye) <<< 2) + DEC_W'(tcr_pkg::DEC_STEP_POS);
            y_adv = y_reg - XY_W'(1);
        end
        x_adv      = x_reg + XY_W'(1);
        ring_end   = x_adv > y_adv;
        circle_end = cur_rad_reg >= fin_rad_reg;
    end

    // start values; zero thickness acts as one
    assign thick_eff = (thick_reg == '0) ? tcr_pkg::THICK_W'(1) : thick_reg;
    assign start_rad = RAD_W'(base_radius);
    assign new_rad   = (command == tcr_pkg::CMD_START) ? start_rad : cur_rad_reg + RAD_W'(1);
    assign init_y    = signed'({1'b0, new_rad});
    assign init_d    = DEC_W'(tcr_pkg::DEC_INIT) - (signed'(DEC_W'(new_rad)) <<< 1);

    always_comb
    begin
        x_next       = x_reg;
        y_next       = y_reg;
        d_next       = d_reg;
        cur_rad_next = cur_rad_reg;
        fin_rad_next = fin_rad_reg;
        active_next  = active_reg;
        q_push       = 1'b0;
        if (accept)
        begin
            if (command == tcr_pkg::CMD_START)
            begin
                cur_rad_next = start_rad;
                fin_rad_next = start_rad + RAD_W'(thick_eff) - RAD_W'(1);
                x_next       = '0;
                y_next       = init_y;
                d_next       = init_d;
                active_next  = 1'b1;
            end
            else if (active_reg)
            begin
                q_push = 1'b1;
                x_next = x_adv;
                y_next = y_adv;
                d_next = d_adv;
                if (ring_end)
                begin
                    if (circle_end)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        cur_rad_next = new_rad;
                        x_next       = '0;
                        y_next       = init_y;
                        d_next       = init_d;
                    end
                end
            end
        end
    end

    // entry: {x, y, done}; x and y are never negative here
    assign q_data = {x_reg[RAD_W-1:0], y_reg[RAD_W-1:0], ring_end && circle_end};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            d_reg       <= '0;
            cur_rad_reg <= '0;
            fin_rad_reg <= '0;
            active_reg  <= 1'b0;
        end
        else
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            d_reg       <= d_next;
            cur_rad_reg <= cur_rad_next;
            fin_rad_reg <= fin_rad_next;
            active_reg  <= active_next;
        end
    end

endmodule

// ===== rtl/core/tcr_queue.sv =====
module tcr_queue #(
    parameter int WIDTH = 2 * (tcr_pkg::RADIUS_BITS_DEF + 1) + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output tcr_pkg::tcr_q_stat_t stat
);

    logic [WIDTH-1:0] slot0_reg;
    logic [WIDTH-1:0] slot1_reg;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign stat.full  = count_reg == 2'd2;
    assign stat.avail = count_reg != 2'd0;
    assign pop_data   = rd_ptr_reg ? slot1_reg : slot0_reg;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push && !wr_ptr_reg)
        begin
            slot0_reg <= push_data;
        end
        if (push && wr_ptr_reg)
        begin
            slot1_reg <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/tcr_back.sv =====
module tcr_back #(
    parameter int RADIUS_BITS = tcr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = tcr_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tcr_pkg::tcr_q_stat_t                 q_stat,
    output logic                                 q_pop,
    input  logic [2*(((RADIUS_BITS > 7) ? RADIUS_BITS : 7) + 1):0] q_data,
    input  logic [tcr_pkg::CENTER_W-1:0]         center_x,
    input  logic [tcr_pkg::CENTER_W-1:0]         center_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [COORD_BITS-1:0]         point_x,
    output logic signed [COORD_BITS-1:0]         point_y,
    output logic                                 last_of_step,
    output logic                                 circle_done
);

    localparam int RAD_W = ((RADIUS_BITS > 7) ? RADIUS_BITS : 7) + 1;
    localparam int SUM_W = ((RAD_W + 1 > tcr_pkg::CENTER_W + 1) ?
                            RAD_W + 1 : tcr_pkg::CENTER_W + 1) + 1;
    localparam int PW    = (SUM_W > COORD_BITS) ? SUM_W : COORD_BITS;
    localparam logic [tcr_pkg::PT_IDX_W-1:0] LAST_IDX =
        tcr_pkg::PT_IDX_W'(tcr_pkg::POINTS_PER_STEP - 1);

    logic [RAD_W-1:0]             cur_x_reg;
    logic [RAD_W-1:0]             cur_y_reg;
    logic                         cur_done_reg;
    logic                         cur_valid_reg, cur_valid_next;
    logic [tcr_pkg::PT_IDX_W-1:0] idx_reg, idx_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] point_x_reg;
    logic signed [COORD_BITS-1:0] point_y_reg;
    logic                         last_reg;
    logic                         done_reg;

    logic                         out_free;
    logic                         emit;
    logic                         step_end;
    logic [RAD_W-1:0]             a_u, b_u;
    logic signed [PW-1:0]         a_s, b_s, cx_s, cy_s, px, py;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = cur_valid_reg && out_free;
    assign step_end = emit && (idx_reg == LAST_IDX);
    assign q_pop    = q_stat.avail && (!cur_valid_reg || step_end);

    // idx bit 2 swaps x/y, bit 0 negates the x term, bit 1 the y term
    always_comb
    begin
        a_u  = idx_reg[2] ? cur_y_reg : cur_x_reg;
        b_u  = idx_reg[2] ? cur_x_reg : cur_y_reg;
        a_s  = signed'(PW'(a_u));
        b_s  = signed'(PW'(b_u));
        cx_s = signed'(PW'(center_x));
        cy_s = signed'(PW'(center_y));
        px   = idx_reg[0] ? cx_s - a_s : cx_s + a_s;
        py   = idx_reg[1] ? cy_s - b_s : cy_s + b_s;
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (step_end)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + tcr_pkg::PT_IDX_W'(1);
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_x_reg    <= q_data[2*RAD_W:RAD_W+1];
            cur_y_reg    <= q_data[RAD_W:1];
            cur_done_reg <= q_data[0];
        end
        if (emit)
        begin
            point_x_reg <= px[COORD_BITS-1:0];
            point_y_reg <= py[COORD_BITS-1:0];
            last_reg    <= idx_reg == LAST_IDX;
            done_reg    <= (idx_reg == LAST_IDX) && cur_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule
